>>> rtl/bqe_pkg.sv
// Shared types, constants and tables for the billboard quad expander.
`timescale 1ns / 1ps
package bqe_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 15;
  localparam int unsigned BasisLat    = 3 + SqrtSteps + 1 + DivSteps + 1;
  localparam int unsigned SinCosLat   = CordicSteps + 1;
  localparam int unsigned ExtentLat   = 3;
  localparam int unsigned ExtW        = 36;

  localparam logic signed [32:0] CordicGainStart = 33'sd652032874;
  localparam logic [1:0] LastCorner = 2'd3;

  typedef enum logic [1:0] {
    CFG_CAM_UP    = 2'd0,
    CFG_CAM_RIGHT = 2'd1,
    CFG_CAM_FWD   = 2'd2,
    CFG_ALIGN     = 2'd3
  } cfg_idx_e;

  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    q14_t z;
    q14_t y;
    q14_t x;
  } vec3_t;

  typedef logic signed [ExtW-1:0] ext_t;

  typedef struct packed {
    ext_t z;
    ext_t y;
    ext_t x;
  } ext3_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pos3_t;

  typedef struct packed {
    pos3_t       ctr;
    logic [31:0] tint;
    logic [63:0] tex;
  } side_t;

  typedef struct packed {
    logic [47:0] dir;
    logic [31:0] r1;
    logic [31:0] r2;
  } shape_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [47:0]        travel_dir;
    logic [31:0]        half_width;
    logic [31:0]        half_height;
    logic [15:0]        spin;
    logic [31:0]        tint;
    logic [63:0]        tex_rect;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        vert_color;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_corner;
  } out_item_t;

  function automatic logic signed [24:0] atan_val(input logic [3:0] idx);
    logic signed [24:0] v;
    unique case (idx)
      4'd0:    v = 25'sd2097152;
      4'd1:    v = 25'sd1238021;
      4'd2:    v = 25'sd654136;
      4'd3:    v = 25'sd332050;
      4'd4:    v = 25'sd166669;
      4'd5:    v = 25'sd83416;
      4'd6:    v = 25'sd41718;
      4'd7:    v = 25'sd20860;
      4'd8:    v = 25'sd10430;
      4'd9:    v = 25'sd5215;
      4'd10:   v = 25'sd2608;
      4'd11:   v = 25'sd1304;
      4'd12:   v = 25'sd652;
      4'd13:   v = 25'sd326;
      4'd14:   v = 25'sd163;
      default: v = 25'sd81;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/billboard_quad_expand.sv
// Top level of the billboard quad expander: config registers and pipeline.
//
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid_i/in_ready_o  in_data_i: one particle
//  out       output     out_valid_o/out_ready_i out_data_o: one corner
//  cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A particle passes the input register and the basis and extent pipelines into the holder.
// The output holder sends four corners per particle and loads the next as the last is taken.
// The pipeline accepts a new particle every cycle until it backs up behind the holder.
// A stall freezes every stage at once, so nothing is lost or repeated.
// Reset clears the valid bits and the holder and sets the config registers to their defaults.
`timescale 1ns / 1ps
module billboard_quad_expand (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bqe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bqe_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i
);
  import bqe_pkg::*;

  localparam int unsigned Depth = 1 + BasisLat + ExtentLat;

  vec3_t cam_up_q, cam_right_q, cam_fwd_q;
  logic  align_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_up_q    <= 48'h0000_4000_0000;
      cam_right_q <= 48'h0000_0000_4000;
      cam_fwd_q   <= 48'h4000_0000_0000;
      align_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CAM_UP:    cam_up_q    <= cfg_wdata_i;
        CFG_CAM_RIGHT: cam_right_q <= cfg_wdata_i;
        CFG_CAM_FWD:   cam_fwd_q   <= cfg_wdata_i;
        CFG_ALIGN:     align_q     <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  logic             en;
  logic             hold_ready;
  logic [Depth-1:0] v_q;
  in_item_t         in_q;

  assign en         = !v_q[Depth-1] || hold_ready;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  vec3_t r_aligned;

  bqe_basis u_basis (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (vec3_t'(in_q.travel_dir)),
    .f_i   (cam_fwd_q),
    .r_o   (r_aligned)
  );

  logic [15:0] spin_dly;
  q14_t        sin_v, cos_v;

  bqe_delay #(
    .W (16),
    .N (BasisLat - SinCosLat)
  ) u_spin_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (in_q.spin),
    .q_o   (spin_dly)
  );

  bqe_sincos u_sincos (
    .clk_i  (clk_i),
    .en_i   (en),
    .spin_i (spin_dly),
    .sin_o  (sin_v),
    .cos_o  (cos_v)
  );

  shape_t shape_in, shape_dly;

  assign shape_in = '{dir: in_q.travel_dir, r1: in_q.half_width, r2: in_q.half_height};

  bqe_delay #(
    .W ($bits(shape_t)),
    .N (BasisLat)
  ) u_shape_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (shape_in),
    .q_o   (shape_dly)
  );

  side_t side_in, side_dly;

  assign side_in = '{ctr:  '{z: in_q.center_z, y: in_q.center_y, x: in_q.center_x},
                     tint: in_q.tint,
                     tex:  in_q.tex_rect};

  bqe_delay #(
    .W ($bits(side_t)),
    .N (BasisLat + ExtentLat)
  ) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_in),
    .q_o   (side_dly)
  );

  vec3_t t_sel, r_sel;
  ext3_t vr, vt;

  assign t_sel = align_q ? vec3_t'(shape_dly.dir) : cam_up_q;
  assign r_sel = align_q ? r_aligned : cam_right_q;

  bqe_extent u_extent (
    .clk_i (clk_i),
    .en_i  (en),
    .sin_i (sin_v),
    .cos_i (cos_v),
    .t_i   (t_sel),
    .r_i   (r_sel),
    .r1_i  (shape_dly.r1),
    .r2_i  (shape_dly.r2),
    .vr_o  (vr),
    .vt_o  (vt)
  );

  bqe_corner u_corner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (v_q[Depth-1]),
    .vr_i        (vr),
    .vt_i        (vt),
    .side_i      (side_dly),
    .ready_o     (hold_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/bqe_delay.sv
// Enabled shift line that delays a payload by a fixed number of stages.
`timescale 1ns / 1ps
module bqe_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] line_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int unsigned k = 1; k < N; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign q_o = line_q[N-1];

endmodule

>>> rtl/bqe_sincos.sv
// Pipelined rotation CORDIC that yields Q1.14 sine and cosine of the spin angle.
`timescale 1ns / 1ps
module bqe_sincos (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [15:0]   spin_i,
  output bqe_pkg::q14_t sin_o,
  output bqe_pkg::q14_t cos_o
);
  import bqe_pkg::*;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  logic signed [32:0] x_q [CordicSteps];
  logic signed [32:0] y_q [CordicSteps];
  logic signed [24:0] z_q [CordicSteps];
  quad_e              quad_q [CordicSteps];
  q14_t               sin_q, cos_q;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    logic signed [32:0] x_in, y_in;
    logic signed [24:0] z_in;
    quad_e              q_in;
    if (i == 0) begin : g_first
      assign x_in = CordicGainStart;
      assign y_in = '0;
      assign z_in = {3'b000, spin_i[13:0], 8'h00};
      assign q_in = quad_e'(spin_i[15:14]);
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign q_in = quad_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i] <= q_in;
        if (!z_in[24]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - atan_val(4'(i));
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + atan_val(4'(i));
        end
      end
    end
  end

  function automatic q14_t round_clamp(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd32768) >>> 16;
    if (r > 33'sd16384) begin
      return 16'sd16384;
    end else if (r < -33'sd16384) begin
      return -16'sd16384;
    end
    return r[15:0];
  endfunction

  q14_t cr, sr;
  q14_t sin_d, cos_d;

  always_comb begin
    cr = round_clamp(x_q[CordicSteps-1]);
    sr = round_clamp(y_q[CordicSteps-1]);
    unique case (quad_q[CordicSteps-1])
      QUAD_0: begin cos_d = cr;  sin_d = sr;  end
      QUAD_1: begin cos_d = -sr; sin_d = cr;  end
      QUAD_2: begin cos_d = -cr; sin_d = -sr; end
      QUAD_3: begin cos_d = sr;  sin_d = -cr; end
      default: begin cos_d = cr; sin_d = sr;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> rtl/bqe_basis.sv
// Pipelined normalized cross product of travel direction and camera forward.
`timescale 1ns / 1ps
module bqe_basis (
  input  logic           clk_i,
  input  logic           en_i,
  input  bqe_pkg::vec3_t t_i,
  input  bqe_pkg::vec3_t f_i,
  output bqe_pkg::vec3_t r_o
);
  import bqe_pkg::*;

  // Cross product.
  logic signed [32:0] cr_q [3];
  logic signed [31:0] p_a [3];
  logic signed [31:0] p_b [3];

  always_comb begin
    p_a[0] = t_i.y * f_i.z;
    p_b[0] = t_i.z * f_i.y;
    p_a[1] = t_i.z * f_i.x;
    p_b[1] = t_i.x * f_i.z;
    p_a[2] = t_i.x * f_i.y;
    p_b[2] = t_i.y * f_i.x;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        cr_q[c] <= 33'(p_a[c]) - 33'(p_b[c]);
      end
    end
  end

  // Magnitudes and squares.
  logic [30:0] mag_q [3];
  logic        neg_q [3];
  logic [61:0] sq_q  [3];
  logic [32:0] abs_v [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      abs_v[c] = cr_q[c][32] ? 33'(-cr_q[c]) : 33'(cr_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        mag_q[c] <= abs_v[c][30:0];
        neg_q[c] <= cr_q[c][32];
        sq_q[c]  <= abs_v[c][30:0] * abs_v[c][30:0];
      end
    end
  end

  // Sum of squares.
  logic [63:0] sum_q;
  logic [30:0] mag2_q [3];
  logic        neg2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
      for (int c = 0; c < 3; c++) begin
        mag2_q[c] <= mag_q[c];
        neg2_q[c] <= neg_q[c];
      end
    end
  end

  // Square root, one result bit per stage.
  logic [33:0] rem_q  [SqrtSteps];
  logic [31:0] root_q [SqrtSteps];
  logic [63:0] rad_q  [SqrtSteps];
  logic [30:0] smag_q [SqrtSteps][3];
  logic        sneg_q [SqrtSteps][3];

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [30:0] mag_in [3];
    logic        neg_in [3];
    logic [35:0] rem2, trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_q;
      assign mag_in  = mag2_q;
      assign neg_in  = neg2_q;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign mag_in  = smag_q[i-1];
      assign neg_in  = sneg_q[i-1];
    end

    assign rem2  = {rem_in, rad_in[63:62]};
    assign trial = 36'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {rad_in[61:0], 2'b00};
        smag_q[i] <= mag_in;
        sneg_q[i] <= neg_in;
        if (rem2 >= trial) begin
          rem_q[i]  <= 34'(rem2 - trial);
          root_q[i] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[i]  <= rem2[33:0];
          root_q[i] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  // Rounded numerators.
  logic [45:0] num_q [3];
  logic        nneg_q [3];
  logic [31:0] nlen_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nlen_q <= root_q[SqrtSteps-1];
      for (int c = 0; c < 3; c++) begin
        num_q[c]  <= 46'({smag_q[SqrtSteps-1][c], 14'd0}) +
                     46'(root_q[SqrtSteps-1][31:1]);
        nneg_q[c] <= sneg_q[SqrtSteps-1][c];
      end
    end
  end

  // Restoring division, one quotient bit per stage.
  logic [45:0] drem_q [DivSteps][3];
  logic [14:0] dquo_q [DivSteps][3];
  logic        dneg_q [DivSteps][3];
  logic [31:0] dlen_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [45:0] rem_in [3];
    logic [14:0] quo_in [3];
    logic        neg_in [3];
    logic [31:0] len_in;
    logic [45:0] dsh;

    if (i == 0) begin : g_first
      assign rem_in = num_q;
      assign quo_in = '{default: '0};
      assign neg_in = nneg_q;
      assign len_in = nlen_q;
    end else begin : g_next
      assign rem_in = drem_q[i-1];
      assign quo_in = dquo_q[i-1];
      assign neg_in = dneg_q[i-1];
      assign len_in = dlen_q[i-1];
    end

    assign dsh = 46'(len_in) << (DivSteps - 1 - i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dlen_q[i] <= len_in;
        dneg_q[i] <= neg_in;
        for (int c = 0; c < 3; c++) begin
          if (rem_in[c] >= dsh) begin
            drem_q[i][c] <= rem_in[c] - dsh;
            dquo_q[i][c] <= {quo_in[c][13:0], 1'b1};
          end else begin
            drem_q[i][c] <= rem_in[c];
            dquo_q[i][c] <= {quo_in[c][13:0], 1'b0};
          end
        end
      end
    end
  end

  // Sign and zero-length handling.
  q14_t r_d [3];
  q14_t r_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dlen_q[DivSteps-1] == '0) begin
        r_d[c] = '0;
      end else if (dneg_q[DivSteps-1][c]) begin
        r_d[c] = -$signed({1'b0, dquo_q[DivSteps-1][c]});
      end else begin
        r_d[c] = $signed({1'b0, dquo_q[DivSteps-1][c]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign r_o = '{z: r_q[2], y: r_q[1], x: r_q[0]};

endmodule

>>> rtl/bqe_extent.sv
// Pipelined half-extent vectors Vr and Vt from angle, basis and half sizes.
`timescale 1ns / 1ps
module bqe_extent (
  input  logic           clk_i,
  input  logic           en_i,
  input  bqe_pkg::q14_t  sin_i,
  input  bqe_pkg::q14_t  cos_i,
  input  bqe_pkg::vec3_t t_i,
  input  bqe_pkg::vec3_t r_i,
  input  logic [31:0]    r1_i,
  input  logic [31:0]    r2_i,
  output bqe_pkg::ext3_t vr_o,
  output bqe_pkg::ext3_t vt_o
);
  import bqe_pkg::*;

  q14_t               tv [3];
  q14_t               rv [3];
  logic signed [31:0] st [3];
  logic signed [31:0] ct [3];
  logic signed [31:0] sr [3];
  logic signed [31:0] cr [3];

  assign tv = '{t_i.x, t_i.y, t_i.z};
  assign rv = '{r_i.x, r_i.y, r_i.z};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      st[j] = sin_i * tv[j];
      ct[j] = cos_i * tv[j];
      sr[j] = sin_i * rv[j];
      cr[j] = cos_i * rv[j];
    end
  end

  logic signed [31:0] wr_q [3];
  logic signed [31:0] wt_q [3];
  logic [31:0]        r1_q, r2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_i;
      r2_q <= r2_i;
      for (int j = 0; j < 3; j++) begin
        wr_q[j] <= st[j] + cr[j];
        wt_q[j] <= ct[j] - sr[j];
      end
    end
  end

  logic signed [64:0] pr_q [3];
  logic signed [64:0] pt_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        pr_q[j] <= $signed({1'b0, r1_q}) * wr_q[j];
        pt_q[j] <= $signed({1'b0, r2_q}) * wt_q[j];
      end
    end
  end

  ext_t vr_q [3];
  ext_t vt_q [3];
  logic signed [64:0] rr [3];
  logic signed [64:0] rt [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rr[j] = (pr_q[j] + 65'sd134217728) >>> 28;
      rt[j] = (pt_q[j] + 65'sd134217728) >>> 28;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        vr_q[j] <= rr[j][ExtW-1:0];
        vt_q[j] <= rt[j][ExtW-1:0];
      end
    end
  end

  assign vr_o = '{z: vr_q[2], y: vr_q[1], x: vr_q[0]};
  assign vt_o = '{z: vt_q[2], y: vt_q[1], x: vt_q[0]};

endmodule

>>> rtl/bqe_corner.sv
// Output holder that emits the four saturated corners of one quad.
`timescale 1ns / 1ps
module bqe_corner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bqe_pkg::ext3_t     vr_i,
  input  bqe_pkg::ext3_t     vt_i,
  input  bqe_pkg::side_t     side_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bqe_pkg::out_item_t out_data_o
);
  import bqe_pkg::*;

  logic       hv_q;
  logic [1:0] cnt_q;
  ext3_t      vr_q, vt_q;
  side_t      side_q;
  logic       done;

  assign done    = hv_q && out_ready_i && (cnt_q == LastCorner);
  assign ready_o = !hv_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      cnt_q <= '0;
    end else if (load_i && ready_o) begin
      hv_q  <= 1'b1;
      cnt_q <= '0;
    end else if (done) begin
      hv_q <= 1'b0;
    end else if (hv_q && out_ready_i) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      vr_q   <= vr_i;
      vt_q   <= vt_i;
      side_q <= side_i;
    end
  end

  function automatic logic signed [31:0] corner(input logic signed [31:0] c,
                                                input ext_t t, input ext_t r,
                                                input logic neg_t, input logic neg_r);
    logic signed [37:0] p;
    p = 38'(c) + (neg_t ? -38'(t) : 38'(t)) + (neg_r ? -38'(r) : 38'(r));
    if (p > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (p < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return p[31:0];
  endfunction

  logic neg_t, neg_r;

  assign neg_t = !cnt_q[0];
  assign neg_r = !cnt_q[1];

  always_comb begin
    out_data_o.vert_x      = corner(side_q.ctr.x, vt_q.x, vr_q.x, neg_t, neg_r);
    out_data_o.vert_y      = corner(side_q.ctr.y, vt_q.y, vr_q.y, neg_t, neg_r);
    out_data_o.vert_z      = corner(side_q.ctr.z, vt_q.z, vr_q.z, neg_t, neg_r);
    out_data_o.vert_color  = side_q.tint;
    out_data_o.tex_u       = cnt_q[1] ? side_q.tex[47:32] : side_q.tex[15:0];
    out_data_o.tex_v       = cnt_q[0] ? side_q.tex[31:16] : side_q.tex[63:48];
    out_data_o.last_corner = (cnt_q == LastCorner);
  end

  assign out_valid_o = hv_q;

endmodule

>>> rtl/bqe_checker.sv
// Port-level checks for the billboard quad expander, bound to the top level.
`timescale 1ns / 1ps
module bqe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bqe_pkg::out_item_t out_data_o
);
  import bqe_pkg::*;

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output payload changed under stall");

  // Corners of one quad follow without a gap and share the color.
  a_quad_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_corner
      |=> out_valid_o && $stable(out_data_o.vert_color))
    else $error("quad corners split or color changed");

  // Nothing is offered right after reset is released.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid after reset");

  // The holder never blocks intake while it shows no transaction.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind billboard_quad_expand bqe_checker u_bqe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
